FILE: hdl/aist_pkg.sv
// Shared types, codes and constants for the auxiliary input status tracker.
// No dependencies; every other file of the block imports this package.
package aist_pkg;

   // Input function type codes, numbered as in the standard
   localparam logic [3:0] FT_LATCH_BOOL        = 4'd0;
   localparam logic [3:0] FT_ANALOG            = 4'd1;
   localparam logic [3:0] FT_NONLATCH_BOOL     = 4'd2;
   localparam logic [3:0] FT_ANALOG_RET50      = 4'd3;
   localparam logic [3:0] FT_ANALOG_RET0       = 4'd4;
   localparam logic [3:0] FT_DUAL_BOTH_LATCH   = 4'd5;
   localparam logic [3:0] FT_DUAL_BOTH_NONLAT  = 4'd6;
   localparam logic [3:0] FT_DUAL_LATCH_UP     = 4'd7;
   localparam logic [3:0] FT_DUAL_LATCH_DOWN   = 4'd8;
   localparam logic [3:0] FT_COMB_RET50_DUAL   = 4'd9;
   localparam logic [3:0] FT_COMB_ANALOG_DUAL  = 4'd10;
   localparam logic [3:0] FT_QUAD_BOOL_NONLAT  = 4'd11;
   localparam logic [3:0] FT_QUAD_ANALOG       = 4'd12;
   localparam logic [3:0] FT_QUAD_ANALOG_RET50 = 4'd13;
   localparam logic [3:0] FT_ENCODER           = 4'd14;
   localparam logic [3:0] FT_UNDEFINED         = 4'd15;

   // Command codes
   localparam logic [1:0] CMD_SET_VALUE = 2'd0;
   localparam logic [1:0] CMD_SENT      = 2'd1;
   localparam logic [1:0] CMD_INIT      = 2'd2;

   // Learn flag selection codes
   localparam logic [1:0] LEARN_FROM_VALUE = 2'd0;
   localparam logic [1:0] LEARN_FORCE_ON   = 2'd1;
   localparam logic [1:0] LEARN_FORCE_OFF  = 2'd2;

   // Boolean codes: pressed and held states of a two-bit switch field
   localparam logic [15:0] VAL_OFF       = 16'h0000;
   localparam logic [15:0] VAL_PRESSED   = 16'h0001;
   localparam logic [15:0] VAL_HELD      = 16'h0002;
   localparam logic [15:0] VAL_PRESSED_B = 16'h0004;
   localparam logic [15:0] VAL_HELD_B    = 16'h0008;
   localparam logic [15:0] VAL_ALL_ONES  = 16'hFFFF;
   localparam logic [1:0]  QUAD_PRESSED  = 2'b01;
   localparam logic [1:0]  QUAD_HELD     = 2'b10;
   localparam int          QUAD_FIELDS   = 4;

   // Configuration register indexes
   localparam int         CSR_INDEX_W       = 1;
   localparam int         CSR_DATA_W        = 4;
   localparam logic [0:0] CSR_FUNCTION_TYPE = 1'b0;
   localparam logic [0:0] CSR_FORCE_OFF     = 1'b1;

   // Forced off sequencing: what the next message must carry
   typedef enum logic [2:0] {
      MODE_INACTIVE = 3'b001,
      MODE_ON       = 3'b010,
      MODE_OFF      = 3'b100
   } aist_mode_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [15:0] new_value1;
      logic [15:0] new_value2;
      logic [1:0]  learn_select;
   } aist_req_type;

   typedef struct packed {
      logic [15:0] value1_out;
      logic [15:0] value2_out;
      logic        learn_active;
      logic        high_rate;
      logic        change_pending;
      logic        send_request;
   } aist_rsp_type;

   typedef struct packed {
      logic [3:0] function_type;
      logic       force_off;
   } aist_cfg_type;

   typedef struct packed {
      logic [15:0]   primary_value;
      logic [15:0]   secondary_value;
      logic          learn_flag;
      logic          fast_rate_flag;
      logic          pending_flag;
      aist_mode_type mode;
   } aist_state_type;

endpackage

FILE: hdl/aist_status_tracker.sv
// Top level of the auxiliary input status tracker: state and result registers.
// Depends on aist_pkg, aist_csr and aist_update.
//
// Each accepted command word yields exactly one status word, registered and
// offered on the rsp channel in the cycle after acceptance. A new word is taken
// every cycle while the result register is empty or being drained, so the
// sustained rate is one word per clock; the single result register is the only
// buffer, and the next-state logic is one pass over the tracker state.
module aux_input_status_tracker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  aist_pkg::aist_req_type            req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output aist_pkg::aist_rsp_type            rsp_data,
   input  logic                              csr_we,
   input  logic [aist_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [aist_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import aist_pkg::*;

   aist_cfg_type   cfg;
   aist_state_type state_ff;
   aist_state_type state_in;
   aist_state_type upd_state;
   logic           upd_send;
   logic           req_accept;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   aist_rsp_type   rsp_ff;
   aist_rsp_type   rsp_in;

   aist_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   aist_update u_update (
      .cfg          (cfg),
      .cur          (state_ff),
      .req          (req_data),
      .nxt          (upd_state),
      .send_request (upd_send)
   );

   // Handshake: accept while the result slot is free or leaving
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      state_in     = req_accept ? upd_state : state_ff;
      rsp_valid_in = req_accept || (rsp_valid_ff && !rsp_ready);
      rsp_in       = rsp_ff;
      if (req_accept) begin
         rsp_in.value1_out     = upd_state.primary_value;
         rsp_in.value2_out     = upd_state.secondary_value;
         rsp_in.learn_active   = upd_state.learn_flag;
         rsp_in.high_rate      = upd_state.fast_rate_flag;
         rsp_in.change_pending = upd_state.pending_flag;
         rsp_in.send_request   = upd_send;
      end
   end

   // Control and tracker state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff                 <= '{16'd0, 16'd0, 1'b0, 1'b0, 1'b0, MODE_INACTIVE};
         rsp_valid_ff             <= 1'b0;
      end else begin
         state_ff                 <= state_in;
         rsp_valid_ff             <= rsp_valid_in;
      end
   end

   // Result word, no reset needed
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A send request always comes with the pending flag set
   a_send_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.send_request |-> rsp_ff.change_pending)
      else $error("send request without pending flag");

   // Tracker state moves only on an accepted word
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> $stable(state_ff))
      else $error("state changed without an accepted word");

   // Forced off sequencing is frozen while the mode is disabled
   a_mode_frozen: assert property (@(posedge clock) disable iff (reset)
      !cfg.force_off |=> $stable(state_ff.mode))
      else $error("forced off mode moved while disabled");

endmodule

FILE: hdl/aist_csr.sv
// Configuration registers of the tracker: function type and forced off mode.
// Depends on aist_pkg.
module aist_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [aist_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [aist_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output aist_pkg::aist_cfg_type               cfg
);
   import aist_pkg::*;

   aist_cfg_type cfg_ff;
   aist_cfg_type cfg_in;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FUNCTION_TYPE: cfg_in.function_type = csr_wdata[3:0];
            CSR_FORCE_OFF:     cfg_in.force_off     = csr_wdata[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: hdl/aist_update.sv
// Next state logic: applies one command word to the tracker state.
// Depends on aist_pkg.
module aist_update (
   input  aist_pkg::aist_cfg_type   cfg,
   input  aist_pkg::aist_state_type cur,
   input  aist_pkg::aist_req_type   req,
   output aist_pkg::aist_state_type nxt,
   output logic                     send_request
);
   import aist_pkg::*;

   // Sent report on quad boolean: each pressed field becomes held
   function automatic logic [15:0] quad_hold(input logic [15:0] v);
      logic [15:0] r;
      r = v;
      for (int i = 0; i < QUAD_FIELDS; i++) begin
         if (v[2*i +: 2] == QUAD_PRESSED) r[2*i +: 2] = QUAD_HELD;
      end
      return r;
   endfunction

   logic [3:0]    t;
   logic          is_bool;
   logic [15:0]   old1;
   logic          inc1;
   logic          abort;
   logic [15:0]   sec_a;
   logic [15:0]   prim;
   logic [15:0]   sec;
   logic          fast;
   aist_mode_type mode;

   assign t       = cfg.function_type;
   assign is_bool = (t == FT_LATCH_BOOL) || (t == FT_NONLATCH_BOOL);

   // Set value path: effective old value under forced mode
   always_comb begin
      old1 = cur.primary_value;
      if (cfg.force_off) begin
         if (cur.mode == MODE_ON)       old1 = VAL_PRESSED;
         else if (cur.mode == MODE_OFF) old1 = VAL_OFF;
      end
   end

   // Set value path: counter, secondary value, forced off sequencing
   always_comb begin
      inc1  = 1'b0;
      abort = 1'b0;
      if (is_bool) begin
         if (old1 != VAL_OFF && req.new_value1 == VAL_OFF) begin
            inc1 = 1'b0;
         end else if (old1 == VAL_OFF && req.new_value1 == VAL_PRESSED) begin
            inc1 = 1'b1;
         end else begin
            abort = 1'b1;
         end
      end else if (t >= FT_DUAL_BOTH_LATCH && t <= FT_QUAD_BOOL_NONLAT) begin
         inc1 = (old1 != req.new_value1);
      end

      if (t >= FT_QUAD_ANALOG && t <= FT_ENCODER) sec_a = req.new_value2;
      else sec_a = cur.secondary_value + {15'd0, inc1};

      prim = req.new_value1;
      sec  = sec_a;
      mode = cur.mode;
      if (cfg.force_off && is_bool && cur.pending_flag) begin
         if (cur.mode == MODE_INACTIVE) begin
            if (old1 == VAL_OFF) begin
               prim = old1;
               sec  = cur.secondary_value;
               mode = MODE_ON;
            end else if (old1 == VAL_PRESSED) begin
               prim = old1;
               sec  = cur.secondary_value;
               mode = MODE_OFF;
            end
         end else begin
            if (cur.mode == MODE_ON) sec = sec_a + 16'd1;
            prim = (cur.mode == MODE_OFF) ? VAL_PRESSED : VAL_OFF;
            mode = MODE_INACTIVE;
         end
      end

      // High rate flag by type
      case (t)
         FT_NONLATCH_BOOL, FT_DUAL_BOTH_NONLAT, FT_QUAD_BOOL_NONLAT:
            fast = (prim != VAL_OFF);
         FT_DUAL_LATCH_UP:   fast = (prim == VAL_PRESSED_B);
         FT_DUAL_LATCH_DOWN: fast = (prim == VAL_PRESSED);
         default:            fast = cur.fast_rate_flag;
      endcase
   end

   // Command dispatch
   always_comb begin
      nxt          = cur;
      send_request = 1'b0;
      case (req.cmd)
         CMD_SET_VALUE: begin
            case (req.learn_select)
               LEARN_FROM_VALUE: nxt.learn_flag = (req.new_value1 != VAL_OFF);
               LEARN_FORCE_ON:   nxt.learn_flag = 1'b1;
               LEARN_FORCE_OFF:  nxt.learn_flag = 1'b0;
               default:          nxt.learn_flag = cur.learn_flag;
            endcase
            if (!abort) begin
               nxt.primary_value   = prim;
               nxt.secondary_value = sec;
               nxt.mode            = mode;
               nxt.fast_rate_flag  = fast;
               if (old1 != prim || cur.secondary_value != sec) begin
                  nxt.pending_flag = 1'b1;
                  send_request     = 1'b1;
               end
            end
         end
         CMD_SENT: begin
            nxt.pending_flag = 1'b0;
            if (cfg.force_off && cur.mode != MODE_INACTIVE) begin
               // emit the pending forced message next
               if (cur.mode == MODE_ON) begin
                  nxt.secondary_value = cur.secondary_value + 16'd1;
               end
               nxt.primary_value  = (cur.mode == MODE_ON) ? VAL_PRESSED : VAL_OFF;
               nxt.mode           = MODE_INACTIVE;
               nxt.pending_flag   = 1'b1;
               nxt.fast_rate_flag = (t == FT_NONLATCH_BOOL) && (cur.mode == MODE_ON);
            end else begin
               // pressed codes turn into held codes
               case (t)
                  FT_NONLATCH_BOOL, FT_DUAL_LATCH_DOWN: begin
                     if (cur.primary_value == VAL_PRESSED) nxt.primary_value = VAL_HELD;
                  end
                  FT_DUAL_BOTH_NONLAT: begin
                     if (cur.primary_value == VAL_PRESSED) nxt.primary_value = VAL_HELD;
                     else if (cur.primary_value == VAL_PRESSED_B) begin
                        nxt.primary_value = VAL_HELD_B;
                     end
                  end
                  FT_DUAL_LATCH_UP: begin
                     if (cur.primary_value == VAL_PRESSED_B) nxt.primary_value = VAL_HELD_B;
                  end
                  FT_QUAD_BOOL_NONLAT: nxt.primary_value = quad_hold(cur.primary_value);
                  default: nxt.primary_value = cur.primary_value;
               endcase
            end
         end
         CMD_INIT: begin
            case (t)
               FT_ANALOG, FT_ANALOG_RET50, FT_ANALOG_RET0:
                  nxt.secondary_value = VAL_ALL_ONES;
               FT_UNDEFINED: nxt.secondary_value = cur.secondary_value;
               default:      nxt.secondary_value = VAL_OFF;
            endcase
         end
         default: nxt = cur;
      endcase
   end

endmodule
